// ===== hdl/mlptf_pkg.sv =====
// Shared types, constants and the control-store program for the tanh perceptron.
// No dependencies; used by mlp_tanh_forward_pass.

package mlptf_pkg;

	localparam int DefInputCount    = 8;
	localparam int DefHiddenCount   = 8;
	localparam int DefOutputCount   = 6;
	localparam int DefTanhTableSize = 256;

	localparam int FieldInputs  = 8;
	localparam int FieldOutputs = 6;
	localparam int ValW         = 16;
	localparam int ResW         = 14;
	localparam int TanhW        = 13;
	localparam int ProdW        = 32;
	localparam int SatShift     = 26;
	localparam int SatW         = SatShift + 1;
	localparam int ModBase      = 17;
	localparam int ModW         = 5;

	typedef logic signed [ValW-1:0] val_t;
	typedef logic signed [ResW-1:0] res_t;
	typedef logic [2:0]             step_t;

	typedef enum logic [2:0] {
		CondNext,
		CondJump,
		CondStart,
		CondMore,
		CondDrain
	} cond_t;

	localparam step_t StepIdle     = 3'd0;
	localparam step_t StepHid      = 3'd1;
	localparam step_t StepHidDrain = 3'd2;
	localparam step_t StepOut      = 3'd3;
	localparam step_t StepOutDrain = 3'd4;
	localparam step_t StepDone     = 3'd5;

	typedef struct packed {
		logic  busy;
		logic  issue;
		logic  layer;
		logic  done;
		cond_t cond;
		step_t target;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t c;
		c = '{busy: 1'b1, issue: 1'b0, layer: 1'b0, done: 1'b0, cond: CondJump,
			target: StepIdle};
		case (pc)
			StepIdle: begin
				c.busy   = 1'b0;
				c.cond   = CondStart;
				c.target = StepHid;
			end
			StepHid: begin
				c.issue  = 1'b1;
				c.cond   = CondMore;
				c.target = StepHid;
			end
			StepHidDrain: begin
				c.cond   = CondDrain;
				c.target = StepHidDrain;
			end
			StepOut: begin
				c.issue  = 1'b1;
				c.layer  = 1'b1;
				c.cond   = CondMore;
				c.target = StepOut;
			end
			StepOutDrain: begin
				c.layer  = 1'b1;
				c.cond   = CondDrain;
				c.target = StepOutDrain;
			end
			StepDone: begin
				c.done   = 1'b1;
				c.cond   = CondJump;
				c.target = StepIdle;
			end
			default: begin
				c.busy   = 1'b0;
				c.cond   = CondJump;
				c.target = StepIdle;
			end
		endcase
		return c;
	endfunction

	// power-on weight for slot phase m = slot mod 17: round((m - 8) * 0.1) in Q3.12
	function automatic val_t default_weight(input logic [ModW-1:0] m);
		val_t w;
		case (m)
			5'd0:    w = -16'sd3277;
			5'd1:    w = -16'sd2867;
			5'd2:    w = -16'sd2458;
			5'd3:    w = -16'sd2048;
			5'd4:    w = -16'sd1638;
			5'd5:    w = -16'sd1229;
			5'd6:    w = -16'sd819;
			5'd7:    w = -16'sd410;
			5'd8:    w = 16'sd0;
			5'd9:    w = 16'sd410;
			5'd10:   w = 16'sd819;
			5'd11:   w = 16'sd1229;
			5'd12:   w = 16'sd1638;
			5'd13:   w = 16'sd2048;
			5'd14:   w = 16'sd2458;
			5'd15:   w = 16'sd2867;
			5'd16:   w = 16'sd3277;
			default: w = 16'sd0;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/mlp_tanh_forward_pass.sv =====
// Fully connected perceptron with tanh on hidden and output layers, no biases.
// Depends on mlptf_pkg (types, control-store program, power-on weight table).

// Usage: a transaction is taken when start is high and busy is low. A weight write
// (req_type 0) completes in the accepting cycle and gives no result. An evaluation
// (req_type 1) holds busy while the single shared multiply-accumulate, which
// consumes one weight per cycle, works through every weight of both layers,
// with a pipeline drain after each layer and one closing step. The six
// outputs are then valid for exactly one cycle with done high; there is no
// back-pressure, so the receiver must capture them in that cycle. After reset
// the weight store reads its power-on pattern at once.

module mlp_tanh_forward_pass #(
	parameter int N_INPUTS        = mlptf_pkg::DefInputCount,
	parameter int N_HIDDEN        = mlptf_pkg::DefHiddenCount,
	parameter int N_OUTPUTS       = mlptf_pkg::DefOutputCount,
	parameter int TANH_TABLE_SIZE = mlptf_pkg::DefTanhTableSize
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [6:0]           weight_index,
	input  mlptf_pkg::val_t      weight_value,
	input  mlptf_pkg::val_t      input_0,
	input  mlptf_pkg::val_t      input_1,
	input  mlptf_pkg::val_t      input_2,
	input  mlptf_pkg::val_t      input_3,
	input  mlptf_pkg::val_t      input_4,
	input  mlptf_pkg::val_t      input_5,
	input  mlptf_pkg::val_t      input_6,
	input  mlptf_pkg::val_t      input_7,
	output logic                 done,
	output mlptf_pkg::res_t      out_turn,
	output mlptf_pkg::res_t      out_speed,
	output mlptf_pkg::res_t      out_aggression,
	output mlptf_pkg::res_t      out_fear,
	output mlptf_pkg::res_t      out_social,
	output mlptf_pkg::res_t      out_explore
);

	localparam int StoreDepth = N_INPUTS * N_HIDDEN + N_HIDDEN * N_OUTPUTS;
	localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
	localparam int JMax       = (N_INPUTS > N_HIDDEN) ? N_INPUTS : N_HIDDEN;
	localparam int RMax       = (N_HIDDEN > N_OUTPUTS) ? N_HIDDEN : N_OUTPUTS;
	localparam int JW         = (JMax > 1) ? $clog2(JMax) : 1;
	localparam int RW         = (RMax > 1) ? $clog2(RMax) : 1;
	localparam int InIdxW     = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
	localparam int HidIdxW    = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
	localparam int OutIdxW    = (N_OUTPUTS > 1) ? $clog2(N_OUTPUTS) : 1;
	localparam int AccW       = mlptf_pkg::ProdW + $clog2(JMax) + 1;
	localparam int TIdxW      = $clog2(TANH_TABLE_SIZE);
	localparam int TScaledW   = $clog2(TANH_TABLE_SIZE + 1);
	localparam int ScaleW     = mlptf_pkg::SatShift + TScaledW;

	localparam logic [JW-1:0]              LastInJ   = JW'(N_INPUTS - 1);
	localparam logic [JW-1:0]              LastHidJ  = JW'(N_HIDDEN - 1);
	localparam logic [RW-1:0]              LastHidR  = RW'(N_HIDDEN - 1);
	localparam logic [RW-1:0]              LastOutR  = RW'(N_OUTPUTS - 1);
	localparam logic [mlptf_pkg::ModW-1:0] LastMod   = mlptf_pkg::ModW'(mlptf_pkg::ModBase - 1);
	localparam logic [AccW-1:0]            SatAcc    = AccW'(1) << mlptf_pkg::SatShift;
	localparam logic [ScaleW-1:0]          RoundHalf = ScaleW'(1) << (mlptf_pkg::SatShift - 1);
	localparam logic [ScaleW-1:0]          TSize     = ScaleW'(TANH_TABLE_SIZE);
	localparam logic [TScaledW-1:0]        TLastWide = TScaledW'(TANH_TABLE_SIZE - 1);
	localparam logic [TIdxW-1:0]           TLast     = TIdxW'(TANH_TABLE_SIZE - 1);
	localparam longint unsigned            OneQ32    = 64'h1_0000_0000;

	// unsigned quotient by shift and subtract; elaboration only
	function automatic longint unsigned udiv64(input longint unsigned a,
		input longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			q = {q[62:0], 1'b0};
			if (r >= b) begin
				r    = r - b;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4k/N) in Q.12 via a Q.32 Taylor sum of e^(8k/N); elaboration only
	function automatic logic [mlptf_pkg::TanhW-1:0] tanh_entry(input longint unsigned k);
		longint unsigned e;
		longint unsigned term;
		longint unsigned num;
		longint unsigned den;
		int unsigned     n;
		logic            stop;
		e    = OneQ32;
		term = OneQ32;
		stop = 1'b0;
		for (n = 1; n < 400; n++) begin
			if (!stop) begin
				term = udiv64(term * (64'd8 * k), 64'(TANH_TABLE_SIZE) * 64'(n));
				if (term == 64'd0)
					stop = 1'b1;
				else
					e = e + term;
			end
		end
		num = e - OneQ32;
		den = e + OneQ32;
		return mlptf_pkg::TanhW'(udiv64(num * 64'd4096 + (den >> 1), den));
	endfunction

	logic [mlptf_pkg::TanhW-1:0] tanh_rom [TANH_TABLE_SIZE];

	for (genvar k = 0; k < TANH_TABLE_SIZE; k++) begin : g_tanh
		localparam logic [mlptf_pkg::TanhW-1:0] Entry = tanh_entry(64'(k));
		assign tanh_rom[k] = Entry;
	end

	// sequencer
	mlptf_pkg::step_t step_q;
	mlptf_pkg::step_t step_nxt;
	mlptf_pkg::ctrl_t ctrl;

	logic accept;
	logic eval_acc;
	logic wr_en;
	logic last_issue;
	logic pipe_busy;
	logic done_q;

	logic [AddrW-1:0]              addr_q;
	logic [mlptf_pkg::ModW-1:0]    mod_q;
	logic [JW-1:0]                 j_q;
	logic [RW-1:0]                 r_q;
	logic [JW-1:0]                 last_j;
	logic [RW-1:0]                 last_r;

	mlptf_pkg::val_t in_fld [mlptf_pkg::FieldInputs];
	mlptf_pkg::val_t x_q    [N_INPUTS];
	mlptf_pkg::val_t hid_q  [N_HIDDEN];
	mlptf_pkg::res_t out_q  [N_OUTPUTS];
	mlptf_pkg::res_t res    [mlptf_pkg::FieldOutputs];

	mlptf_pkg::val_t wmem   [StoreDepth];
	logic            wvld_q [StoreDepth];
	logic [AddrW-1:0] wr_addr;

	assign in_fld[0] = input_0;
	assign in_fld[1] = input_1;
	assign in_fld[2] = input_2;
	assign in_fld[3] = input_3;
	assign in_fld[4] = input_4;
	assign in_fld[5] = input_5;
	assign in_fld[6] = input_6;
	assign in_fld[7] = input_7;

	always_comb begin
		ctrl = mlptf_pkg::ucode(step_q);
	end

	assign busy     = ctrl.busy;
	assign accept   = start && !busy;
	assign eval_acc = accept && req_type;
	assign wr_addr  = AddrW'(weight_index);
	assign wr_en    = accept && !req_type && (32'(weight_index) < 32'(StoreDepth));

	assign last_j     = ctrl.layer ? LastHidJ : LastInJ;
	assign last_r     = ctrl.layer ? LastOutR : LastHidR;
	assign last_issue = ctrl.issue && (j_q == last_j) && (r_q == last_r);

	always_comb begin
		case (ctrl.cond)
			mlptf_pkg::CondNext:  step_nxt = mlptf_pkg::step_t'(step_q + 1'b1);
			mlptf_pkg::CondJump:  step_nxt = ctrl.target;
			mlptf_pkg::CondStart: step_nxt = eval_acc ? ctrl.target : step_q;
			mlptf_pkg::CondMore:
				step_nxt = last_issue ? mlptf_pkg::step_t'(step_q + 1'b1) : ctrl.target;
			mlptf_pkg::CondDrain:
				step_nxt = pipe_busy ? ctrl.target : mlptf_pkg::step_t'(step_q + 1'b1);
			default:              step_nxt = mlptf_pkg::StepIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mlptf_pkg::StepIdle;
			done_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			done_q <= ctrl.done;
		end
	end

	// weight address walk: slots are read strictly in order over one evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			mod_q  <= '0;
			j_q    <= '0;
			r_q    <= '0;
		end else if (eval_acc) begin
			addr_q <= '0;
			mod_q  <= '0;
			j_q    <= '0;
			r_q    <= '0;
		end else if (ctrl.issue) begin
			addr_q <= AddrW'(addr_q + 1'b1);
			mod_q  <= (mod_q == LastMod) ? '0 : mlptf_pkg::ModW'(mod_q + 1'b1);
			if (j_q == last_j) begin
				j_q <= '0;
				r_q <= (r_q == last_r) ? '0 : RW'(r_q + 1'b1);
			end else begin
				j_q <= JW'(j_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			for (int i = 0; i < N_INPUTS; i++)
				x_q[i] <= in_fld[i];
		end
	end

	// weight store: written slots flagged, unwritten slots read the power-on pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < StoreDepth; i++)
				wvld_q[i] <= 1'b0;
		end else if (wr_en) begin
			wvld_q[wr_addr] <= 1'b1;
		end
	end

	mlptf_pkg::val_t rd_s1;
	mlptf_pkg::val_t dflt_s1;
	mlptf_pkg::val_t opnd_s1;
	logic            vld_s1;
	logic            act_s1;
	logic            first_s1;
	logic            last_s1;
	logic            layer_s1;
	logic [RW-1:0]   row_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			wmem[wr_addr] <= weight_value;
		rd_s1 <= wmem[addr_q];
	end

	always_ff @(posedge clk) begin
		vld_s1   <= wvld_q[addr_q];
		dflt_s1  <= mlptf_pkg::default_weight(mod_q);
		opnd_s1  <= ctrl.layer ? hid_q[j_q[HidIdxW-1:0]] : x_q[j_q[InIdxW-1:0]];
		first_s1 <= (j_q == '0);
		last_s1  <= (j_q == last_j);
		layer_s1 <= ctrl.layer;
		row_s1   <= r_q;
	end

	// multiply
	mlptf_pkg::val_t                w_sel;
	logic signed [mlptf_pkg::ProdW-1:0] prod_s2;
	logic            act_s2;
	logic            first_s2;
	logic            last_s2;
	logic            layer_s2;
	logic [RW-1:0]   row_s2;

	assign w_sel = vld_s1 ? rd_s1 : dflt_s1;

	always_ff @(posedge clk) begin
		prod_s2  <= mlptf_pkg::ProdW'(w_sel) * mlptf_pkg::ProdW'(opnd_s1);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		layer_s2 <= layer_s1;
		row_s2   <= row_s1;
	end

	// accumulate
	logic signed [AccW-1:0] acc_q;
	logic            fin_s3;
	logic            layer_s3;
	logic [RW-1:0]   row_s3;

	always_ff @(posedge clk) begin
		if (act_s2) begin
			acc_q    <= first_s2 ? AccW'(prod_s2) : AccW'(acc_q + AccW'(prod_s2));
			layer_s3 <= layer_s2;
			row_s3   <= row_s2;
		end
	end

	// saturate magnitude to 4.0
	logic [AccW-1:0]           acc_mag;
	logic [mlptf_pkg::SatW-1:0] sat_t1;
	logic                      neg_t1;
	logic                      v_t1;
	logic                      layer_t1;
	logic [RW-1:0]             row_t1;

	assign acc_mag = acc_q[AccW-1] ? AccW'(~acc_q + 1'b1) : AccW'(acc_q);

	always_ff @(posedge clk) begin
		sat_t1   <= (acc_mag > SatAcc) ? mlptf_pkg::SatW'(SatAcc)
			: acc_mag[mlptf_pkg::SatW-1:0];
		neg_t1   <= acc_q[AccW-1];
		layer_t1 <= layer_s3;
		row_t1   <= row_s3;
	end

	// table index, rounded and clamped
	logic [ScaleW-1:0]   scaled;
	logic [TScaledW-1:0] scaled_idx;
	logic [TIdxW-1:0]    idx_t2;
	logic                neg_t2;
	logic                v_t2;
	logic                layer_t2;
	logic [RW-1:0]       row_t2;

	assign scaled     = ScaleW'(ScaleW'(sat_t1) * TSize + RoundHalf);
	assign scaled_idx = scaled[ScaleW-1:mlptf_pkg::SatShift];

	always_ff @(posedge clk) begin
		idx_t2   <= (scaled_idx > TLastWide) ? TLast : scaled_idx[TIdxW-1:0];
		neg_t2   <= neg_t1;
		layer_t2 <= layer_t1;
		row_t2   <= row_t1;
	end

	// lookup and write-back
	logic [mlptf_pkg::TanhW-1:0] t_val;
	mlptf_pkg::res_t             t_res;

	assign t_val = tanh_rom[idx_t2];
	assign t_res = neg_t2 ? mlptf_pkg::ResW'(-$signed({1'b0, t_val}))
		: mlptf_pkg::ResW'($signed({1'b0, t_val}));

	always_ff @(posedge clk) begin
		if (v_t2 && !layer_t2)
			hid_q[row_t2[HidIdxW-1:0]] <= mlptf_pkg::ValW'(t_res);
		if (v_t2 && layer_t2)
			out_q[row_t2[OutIdxW-1:0]] <= t_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
			fin_s3 <= 1'b0;
			v_t1   <= 1'b0;
			v_t2   <= 1'b0;
		end else begin
			act_s1 <= ctrl.issue;
			act_s2 <= act_s1;
			fin_s3 <= act_s2 && last_s2;
			v_t1   <= fin_s3;
			v_t2   <= v_t1;
		end
	end

	assign pipe_busy = act_s1 || act_s2 || fin_s3 || v_t1 || v_t2;

	for (genvar o = 0; o < mlptf_pkg::FieldOutputs; o++) begin : g_res
		if (o < N_OUTPUTS) begin : g_used
			assign res[o] = out_q[o];
		end else begin : g_zero
			assign res[o] = '0;
		end
	end

	assign done           = done_q;
	assign out_turn       = res[0];
	assign out_speed      = res[1];
	assign out_aggression = res[2];
	assign out_fear       = res[3];
	assign out_social     = res[4];
	assign out_explore    = res[5];

endmodule
